// ===== rtl/swbc_pkg.sv =====
// Shared types and constants for the swept box tile collision core.
package swbc_pkg;

   // Field widths
   localparam int TILE_W  = 6;   // tile_col / tile_row
   localparam int POS_W   = 14;  // unsigned Q6.8 position
   localparam int VEL_W   = 14;  // signed Q5.8 velocity
   localparam int DIM_W   = 11;  // Q3.8 box size registers
   localparam int HIT_W   = 7;
   localparam int SIDE_W  = 2;

   // Internal widths
   localparam int COORD_W    = 17;           // signed sample coordinate
   localparam int TILE_IDX_W = COORD_W - 9;  // tile index of a non-negative coordinate
   localparam int QUOT_W     = VEL_W + 1;    // signed per-step offset quotient
   localparam int LOOP_W     = 12;           // box sample offsets, one past the box size
   localparam int PTR_W      = 4;            // eight map reads plus the evaluation beat

   // Sample grid, Q.8 tile units
   localparam int ROW_PITCH  = 128;
   localparam int COL_PITCH  = 230;
   localparam int SIDE_REACH = 128;

   // Input item mode
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_PROBE = 1'b1;

   // Side flag codes
   localparam logic [SIDE_W-1:0] SIDE_NONE  = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd2;

   // Register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 1'b1;

   localparam logic [DIM_W-1:0] DIM_RESET = 11'd256;

endpackage

// ===== rtl/swbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module swbc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/swbc_div.sv =====
// Floor division of a signed velocity by the step count through a reciprocal multiply.
module swbc_div #(
   parameter int DIVISOR = 100
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [swbc_pkg::VEL_W-1:0]       dividend,
   output logic                                    done,
   output logic signed [swbc_pkg::QUOT_W-1:0]      quot,
   output logic [$clog2(DIVISOR+1)-1:0]            rem
);

   import swbc_pkg::*;

   localparam int REM_W   = $clog2(DIVISOR + 1);
   localparam int SHIFT   = VEL_W + $clog2(DIVISOR);
   localparam int RECIP_W = VEL_W + 1;
   localparam int PROD_W  = VEL_W + RECIP_W;
   // rounded-up reciprocal, exact for every magnitude below 2**VEL_W
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / DIVISOR + 1);

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_MUL,
      DV_REM,
      DV_FIX
   } div_state_type;

   div_state_type              state_ff, state_in;
   logic [VEL_W-1:0]           mag_ff, mag_in;     // dividend magnitude
   logic [VEL_W-1:0]           quo_ff, quo_in;     // magnitude quotient
   logic [REM_W-1:0]           part_ff, part_in;   // magnitude remainder
   logic                       neg_ff, neg_in;
   logic                       done_ff, done_in;
   logic signed [QUOT_W-1:0]   quot_ff, quot_in;
   logic [REM_W-1:0]           rem_ff, rem_in;

   logic [PROD_W-1:0]          prod;
   logic [VEL_W-1:0]           back;
   logic [VEL_W-1:0]           diff;

   // quotient by reciprocal, remainder by multiply back and subtract
   assign prod = PROD_W'(mag_ff) * PROD_W'(RECIP);
   assign back = quo_ff * VEL_W'(DIVISOR);
   assign diff = mag_ff - back;

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      quo_in   = quo_ff;
      part_in  = part_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               neg_in   = dividend[VEL_W-1];
               mag_in   = dividend[VEL_W-1] ? VEL_W'(-dividend) : VEL_W'(dividend);
               state_in = DV_MUL;
            end
         end
         DV_MUL: begin
            quo_in   = VEL_W'(prod >> SHIFT);
            state_in = DV_REM;
         end
         DV_REM: begin
            part_in  = diff[REM_W-1:0];
            state_in = DV_FIX;
         end
         DV_FIX: begin
            // round toward minus infinity, remainder kept in 0..DIVISOR-1
            if (neg_ff && part_ff != '0) begin
               quot_in = ~QUOT_W'(quo_ff);
               rem_in  = REM_W'(DIVISOR) - part_ff;
            end else if (neg_ff) begin
               quot_in = -QUOT_W'(quo_ff);
               rem_in  = '0;
            end else begin
               quot_in = QUOT_W'(quo_ff);
               rem_in  = part_ff;
            end
            done_in  = 1'b1;
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      mag_ff  <= mag_in;
      quo_ff  <= quo_in;
      part_ff <= part_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// ===== rtl/swept_box_tile_collision_core.sv =====
// Top level: tile map RAM, step offset divider and the probe sequencer.
// Write items give no result. A probe first runs the two step offset divisions, then for each
// time step a step update and, per box sample, eight map reads through the single RAM read port
// and one evaluation beat; a sweep without a hit ends with a closing step.
// samples = ceil(height/128) * ceil(width/230); rsp_valid is registered.
// Reset clears the map with busy high; results are never stalled.
module swept_box_tile_collision_core #(
   parameter int MAP_COLS   = 64,
   parameter int MAP_ROWS   = 64,
   parameter int TIME_STEPS = 100
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input items
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_mode,
   input  logic [swbc_pkg::TILE_W-1:0]            req_tile_col,
   input  logic [swbc_pkg::TILE_W-1:0]            req_tile_row,
   input  logic                                   req_tile_is_wall,
   input  logic [swbc_pkg::POS_W-1:0]             req_pos_x,
   input  logic [swbc_pkg::POS_W-1:0]             req_pos_y,
   input  logic signed [swbc_pkg::VEL_W-1:0]      req_vel_x,
   input  logic signed [swbc_pkg::VEL_W-1:0]      req_vel_y,
   // results
   output logic                                   rsp_valid,
   output logic [swbc_pkg::HIT_W-1:0]             rsp_hit_step,
   output logic [swbc_pkg::SIDE_W-1:0]            rsp_side_flag,
   // configuration
   input  logic                                   csr_wr_en,
   input  logic [swbc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [swbc_pkg::DIM_W-1:0]             csr_wr_data
);

   import swbc_pkg::*;

   localparam int DEPTH  = MAP_ROWS * MAP_COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int REM_W  = $clog2(TIME_STEPS + 1);
   localparam int STEP_W = $clog2(TIME_STEPS + 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(DEPTH - 1);
   localparam logic [REM_W:0]    STEPS_WIDE = (REM_W + 1)'(TIME_STEPS);
   localparam logic [31:0]       STEPS_32   = 32'(TIME_STEPS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y,
      ST_STEP,
      ST_SAMPLE
   } state_type;

   // coordinate to tile index: {in map, index}; -255..-1 truncates to tile 0
   function automatic logic [TILE_IDX_W:0] tile_decode(input logic [COORD_W-1:0] c,
                                                       input int lim);
      logic [TILE_IDX_W-1:0] idx;
      logic                  ok;
      if (c[COORD_W-1]) begin
         idx = '0;
         ok  = (&c[COORD_W-1:8]) && (c[7:0] != 8'd0);
      end else begin
         idx = c[COORD_W-2:8];
         ok  = (32'(idx) < lim);
      end
      return {ok, idx};
   endfunction

   // registers
   state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]         clr_addr_ff, clr_addr_in;
   logic [DIM_W-1:0]          height_ff, height_in;
   logic [DIM_W-1:0]          width_ff, width_in;
   logic signed [VEL_W-1:0]   vx_ff, vx_in;
   logic signed [VEL_W-1:0]   vy_ff, vy_in;
   logic                      div_start_ff, div_start_in;
   logic [COORD_W-1:0]        px_ff, px_in;
   logic [COORD_W-1:0]        py_ff, py_in;
   logic signed [QUOT_W-1:0]  qvx_ff, qvx_in;
   logic signed [QUOT_W-1:0]  qvy_ff, qvy_in;
   logic [REM_W-1:0]          rvx_ff, rvx_in;
   logic [REM_W-1:0]          rvy_ff, rvy_in;
   logic [REM_W-1:0]          rx_ff, rx_in;
   logic [REM_W-1:0]          ry_ff, ry_in;
   logic [STEP_W-1:0]         n_ff, n_in;
   logic [LOOP_W-1:0]         k_ff, k_in;
   logic [LOOP_W-1:0]         l_ff, l_in;
   logic [PTR_W-1:0]          ptr_ff, ptr_in;
   logic                      pt_ok_ff, pt_ok_in;
   logic [6:0]                wall_ff, wall_in;
   logic [SIDE_W-1:0]         side_ff, side_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [HIT_W-1:0]          rsp_hit_ff, rsp_hit_in;
   logic [SIDE_W-1:0]         rsp_side_ff, rsp_side_in;

   // combinational
   logic                      accept;
   logic                      div_done;
   logic signed [QUOT_W-1:0]  div_quot;
   logic [REM_W-1:0]          div_rem;
   logic signed [VEL_W-1:0]   div_dividend;
   logic                      ram_wr_en;
   logic [ADDR_W-1:0]         ram_wr_addr;
   logic                      ram_wr_data;
   logic                      ram_rd_data;
   logic                      req_in_map;
   logic [ADDR_W-1:0]         req_addr;
   logic [COORD_W-1:0]        x_off, y_off;
   logic [COORD_W-1:0]        pt_x, pt_y;
   logic [TILE_IDX_W:0]       col_dec, row_dec;
   logic [ADDR_W-1:0]         pt_addr;
   logic                      pt_ok;
   logic                      cur_bit;
   logic [7:0]                walls;
   logic [SIDE_W-1:0]         eval_side;
   logic                      eval_hit;
   logic [REM_W:0]            rx_sum, ry_sum;
   logic                      carry_x, carry_y;
   logic [LOOP_W-1:0]         l_next, k_next;
   logic                      empty_box;
   logic [31:0]               hit_wide;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // write item: target tile and range check
   assign req_in_map = (32'(req_tile_col) < MAP_COLS) && (32'(req_tile_row) < MAP_ROWS);
   assign req_addr   = ADDR_W'(req_tile_row) * ADDR_W'(MAP_COLS) + ADDR_W'(req_tile_col);

   // map write port: clearing pass after reset, else write items
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = 1'b0;
      end else begin
         ram_wr_en   = accept && (req_mode == MODE_WRITE) && req_in_map;
         ram_wr_addr = req_addr;
         ram_wr_data = req_tile_is_wall;
      end
   end

   // sample point selection: side probes first, then the four corners
   always_comb begin
      case (ptr_ff[2:0])
         3'd0: begin
            x_off = '0 - COORD_W'(SIDE_REACH);
            y_off = '0;
         end
         3'd1: begin
            x_off = '0 - COORD_W'(SIDE_REACH);
            y_off = COORD_W'(k_ff);
         end
         3'd2: begin
            x_off = COORD_W'(l_ff) + COORD_W'(SIDE_REACH);
            y_off = COORD_W'(k_ff);
         end
         3'd3: begin
            x_off = COORD_W'(l_ff) + COORD_W'(SIDE_REACH);
            y_off = '0;
         end
         3'd4: begin
            x_off = '0;
            y_off = '0;
         end
         3'd5: begin
            x_off = COORD_W'(l_ff);
            y_off = COORD_W'(k_ff);
         end
         3'd6: begin
            x_off = COORD_W'(l_ff);
            y_off = '0;
         end
         default: begin
            x_off = '0;
            y_off = COORD_W'(k_ff);
         end
      endcase
   end

   assign pt_x    = px_ff + x_off;
   assign pt_y    = py_ff + y_off;
   assign col_dec = tile_decode(pt_x, MAP_COLS);
   assign row_dec = tile_decode(pt_y, MAP_ROWS);
   assign pt_ok   = col_dec[TILE_IDX_W] && row_dec[TILE_IDX_W];
   assign pt_addr = ADDR_W'(row_dec[TILE_IDX_W-1:0]) * ADDR_W'(MAP_COLS)
                    + ADDR_W'(col_dec[TILE_IDX_W-1:0]);

   // sample evaluation on the evaluation beat, with the data of the last read
   assign cur_bit = ram_rd_data && pt_ok_ff;
   assign walls   = {cur_bit, wall_ff};
   assign eval_hit = |walls[7:4];
   always_comb begin
      if (walls[0] || walls[1]) begin
         eval_side = SIDE_LEFT;
      end else if (walls[2] || walls[3]) begin
         eval_side = SIDE_RIGHT;
      end else begin
         eval_side = SIDE_NONE;
      end
   end

   // per-step offset: add the floor quotient, carry the remainder
   assign rx_sum  = {1'b0, rx_ff} + {1'b0, rvx_ff};
   assign ry_sum  = {1'b0, ry_ff} + {1'b0, rvy_ff};
   assign carry_x = (rx_sum >= STEPS_WIDE);
   assign carry_y = (ry_sum >= STEPS_WIDE);

   assign l_next    = l_ff + LOOP_W'(COL_PITCH);
   assign k_next    = k_ff + LOOP_W'(ROW_PITCH);
   assign empty_box = (height_ff == '0) || (width_ff == '0);
   assign hit_wide  = 32'(n_ff) - 32'd1;

   assign div_dividend = (state_ff == ST_DIV_Y) ? vy_ff : vx_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      height_in    = height_ff;
      width_in     = width_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      div_start_in = 1'b0;
      px_in        = px_ff;
      py_in        = py_ff;
      qvx_in       = qvx_ff;
      qvy_in       = qvy_ff;
      rvx_in       = rvx_ff;
      rvy_in       = rvy_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      l_in         = l_ff;
      ptr_in       = ptr_ff;
      pt_ok_in     = pt_ok;
      wall_in      = wall_ff;
      side_in      = side_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_side_in  = rsp_side_ff;

      // register writes
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HEIGHT: height_in = csr_wr_data;
            CSR_WIDTH:  width_in  = csr_wr_data;
            default:    ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_mode == MODE_PROBE) begin
               px_in        = COORD_W'(req_pos_x);
               py_in        = COORD_W'(req_pos_y);
               vx_in        = req_vel_x;
               vy_in        = req_vel_y;
               side_in      = SIDE_NONE;
               div_start_in = 1'b1;
               state_in     = ST_DIV_X;
            end
         end
         ST_DIV_X: begin
            if (div_done) begin
               qvx_in       = div_quot;
               rvx_in       = div_rem;
               div_start_in = 1'b1;
               state_in     = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_done) begin
               qvy_in   = div_quot;
               rvy_in   = div_rem;
               rx_in    = '0;
               ry_in    = '0;
               n_in     = '0;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (n_ff == STEP_W'(TIME_STEPS) || empty_box) begin
               // sweep finished without a hit
               rsp_valid_in = 1'b1;
               rsp_hit_in   = STEPS_32[HIT_W-1:0];
               rsp_side_in  = side_ff;
               state_in     = ST_IDLE;
            end else begin
               n_in   = n_ff + 1'b1;
               px_in  = px_ff + COORD_W'(qvx_ff) + COORD_W'(carry_x);
               py_in  = py_ff + COORD_W'(qvy_ff) + COORD_W'(carry_y);
               rx_in  = carry_x ? REM_W'(rx_sum - STEPS_WIDE) : REM_W'(rx_sum);
               ry_in  = carry_y ? REM_W'(ry_sum - STEPS_WIDE) : REM_W'(ry_sum);
               k_in   = '0;
               l_in   = '0;
               ptr_in = '0;
               state_in = ST_SAMPLE;
            end
         end
         ST_SAMPLE: begin
            if (ptr_ff[PTR_W-1]) begin
               side_in = eval_side;
               ptr_in  = '0;
               if (eval_hit) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = hit_wide[HIT_W-1:0];
                  rsp_side_in  = eval_side;
                  state_in     = ST_IDLE;
               end else if (l_next < LOOP_W'(width_ff)) begin
                  l_in = l_next;
               end else if (k_next < LOOP_W'(height_ff)) begin
                  k_in = k_next;
                  l_in = '0;
               end else begin
                  state_in = ST_STEP;
               end
            end else begin
               if (ptr_ff != '0) begin
                  wall_in[3'(ptr_ff - 1'b1)] = cur_bit;
               end
               ptr_in = ptr_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         height_ff    <= DIM_RESET;
         width_ff     <= DIM_RESET;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         height_ff    <= height_in;
         width_ff     <= width_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      qvx_ff      <= qvx_in;
      qvy_ff      <= qvy_in;
      rvx_ff      <= rvx_in;
      rvy_ff      <= rvy_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      l_ff        <= l_in;
      ptr_ff      <= ptr_in;
      pt_ok_ff    <= pt_ok_in;
      wall_ff     <= wall_in;
      side_ff     <= side_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_side_ff <= rsp_side_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit_step  = rsp_hit_ff;
   assign rsp_side_flag = rsp_side_ff;

   // shared floor divider for both velocity components
   swbc_div #(
      .DIVISOR (TIME_STEPS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // tile map
   swbc_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (1'b1),
      .rd_addr (pt_addr),
      .rd_data (ram_rd_data)
   );

endmodule
